FILE: design/sqtch_pkg.sv
// shared constants, codes and helper functions for the square tone channel with sweep
package sqtch_pkg;

  localparam int unsigned FreqW    = 11;
  localparam int unsigned PeriodW  = 13;
  localparam int unsigned LengthW  = 7;
  localparam int unsigned VolW     = 4;
  localparam int unsigned CntW     = 3;
  localparam int unsigned OpW      = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 4;

  localparam logic [LengthW-1:0] LengthFull = 7'd64;
  localparam logic [VolW-1:0]    VolumeMax  = 4'd15;

  // event codes
  localparam logic [OpW-1:0] OpTick     = 3'd0;
  localparam logic [OpW-1:0] OpLength   = 3'd1;
  localparam logic [OpW-1:0] OpSweep    = 3'd2;
  localparam logic [OpW-1:0] OpEnvelope = 3'd3;
  localparam logic [OpW-1:0] OpTrigger  = 3'd4;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgDutyMode      = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSweepPeriod   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSweepSubtract = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSweepShift    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgEnvStartVol   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgEnvIncrease   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgEnvPeriod     = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgLengthEnable  = 3'd7;

  // 2 * (2048 - f)
  function automatic logic [PeriodW-1:0] timer_reload(input logic [FreqW-1:0] f);
    logic [FreqW:0] span;
    span = 12'd2048 - {1'b0, f};
    return {span, 1'b0};
  endfunction

  function automatic logic duty_high(input logic [1:0] mode, input logic [2:0] phase);
    logic lvl;
    case (mode)
      2'd0:    lvl = (phase == 3'd6);
      2'd1:    lvl = (phase >= 3'd6);
      2'd2:    lvl = (phase >= 3'd4);
      default: lvl = (phase <= 3'd5);
    endcase
    return lvl;
  endfunction

  // shadow +/- (shadow >> shift), bit 11 set means overflow
  function automatic logic [FreqW:0] sweep_next(input logic [FreqW-1:0] shadow,
                                                input logic [2:0] shift,
                                                input logic sub);
    logic [FreqW-1:0] delta;
    delta = shadow >> shift;
    if (sub) begin
      return {1'b0, shadow} - {1'b0, delta};
    end else begin
      return {1'b0, shadow} + {1'b0, delta};
    end
  endfunction

endpackage

FILE: design/square_tone_channel_with_sweep_unit.sv
// square tone channel with frequency sweep, envelope and length counter
// an output beat is registered when its input beat is accepted and appears in the next cycle
// throughput: one beat per cycle while the sink keeps up, set by the single state update path
// input stalls only while an output beat waits for a sink that is not ready
// reset: config and channel state clear, length counter loads 64, output data not reset, no beat pending
// the longest path is two sweep adders in series with their overflow checks
module square_tone_channel_with_sweep_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [10:0] frequency_value, [11] sequencer_odd
  input  logic [2:0]  s_axis_tuser,   // [2:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [3:0] sample, [4] channel_on
);

  // configuration
  logic [1:0] duty_mode_q;
  logic [2:0] sweep_period_q;
  logic       sweep_sub_q;
  logic [2:0] sweep_shift_q;
  logic [3:0] env_start_q;
  logic       env_inc_q;
  logic [2:0] env_period_q;
  logic       len_en_q;

  // channel state
  logic                                chan_en_q, chan_en_d;
  logic [sqtch_pkg::FreqW-1:0]         cur_freq_q, cur_freq_d;
  logic [sqtch_pkg::FreqW-1:0]         shadow_q, shadow_d;
  logic [sqtch_pkg::PeriodW-1:0]       period_q, period_d;
  logic [2:0]                          phase_q, phase_d;
  logic                                level_q, level_d;
  logic [sqtch_pkg::VolW-1:0]          vol_q, vol_d;
  logic [sqtch_pkg::CntW-1:0]          env_cnt_q, env_cnt_d;
  logic [sqtch_pkg::CntW-1:0]          sweep_cnt_q, sweep_cnt_d;
  logic                                sweep_act_q, sweep_act_d;
  logic [sqtch_pkg::LengthW-1:0]       len_cnt_q, len_cnt_d;

  logic       out_valid_q;
  logic [7:0] out_data_q;

  logic                          s_acc;
  logic [sqtch_pkg::OpW-1:0]     op;
  logic [sqtch_pkg::FreqW-1:0]   freq_in;
  logic                          odd_in;
  logic [sqtch_pkg::PeriodW-1:0] period_dec;
  logic [2:0]                    phase_inc;
  logic [sqtch_pkg::CntW-1:0]    sweep_dec;
  logic [sqtch_pkg::CntW-1:0]    env_dec;
  logic [sqtch_pkg::FreqW:0]     sweep_a;
  logic [sqtch_pkg::FreqW:0]     sweep_b;
  logic [sqtch_pkg::FreqW-1:0]   shadow_mid;
  logic [sqtch_pkg::FreqW:0]     trig_calc;
  logic [sqtch_pkg::VolW-1:0]    sample_d;

  assign op      = s_axis_tuser;
  assign freq_in = s_axis_tdata[10:0];
  assign odd_in  = s_axis_tdata[11];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign period_dec = period_q - 13'd1;
  assign phase_inc  = phase_q + 3'd1;
  assign sweep_dec  = sweep_cnt_q - 3'd1;
  assign env_dec    = env_cnt_q - 3'd1;

  // two sweep calculations in a row on a sweep step
  assign sweep_a    = sqtch_pkg::sweep_next(shadow_q, sweep_shift_q, sweep_sub_q);
  assign shadow_mid = (!sweep_a[11] && (sweep_shift_q != 3'd0)) ? sweep_a[10:0] : shadow_q;
  assign sweep_b    = sqtch_pkg::sweep_next(shadow_mid, sweep_shift_q, sweep_sub_q);
  assign trig_calc  = sqtch_pkg::sweep_next(freq_in, sweep_shift_q, sweep_sub_q);

  always_comb begin
    chan_en_d   = chan_en_q;
    cur_freq_d  = cur_freq_q;
    shadow_d    = shadow_q;
    period_d    = period_q;
    phase_d     = phase_q;
    level_d     = level_q;
    vol_d       = vol_q;
    env_cnt_d   = env_cnt_q;
    sweep_cnt_d = sweep_cnt_q;
    sweep_act_d = sweep_act_q;
    len_cnt_d   = len_cnt_q;
    case (op)
      sqtch_pkg::OpTick: begin
        if (period_q != '0) begin
          if (period_dec == '0) begin
            period_d = sqtch_pkg::timer_reload(cur_freq_q);
            phase_d  = phase_inc;
            level_d  = sqtch_pkg::duty_high(duty_mode_q, phase_inc);
          end else begin
            period_d = period_dec;
          end
        end
      end
      sqtch_pkg::OpLength: begin
        if (len_en_q && (len_cnt_q != '0)) begin
          len_cnt_d = len_cnt_q - 7'd1;
          if (len_cnt_q == 7'd1) begin
            chan_en_d = 1'b0;
          end
        end
      end
      sqtch_pkg::OpSweep: begin
        sweep_cnt_d = sweep_dec;
        if (sweep_dec == '0) begin
          sweep_cnt_d = sweep_period_q;
          if (sweep_act_q && (sweep_period_q != '0)) begin
            if (sweep_a[11]) begin
              chan_en_d = 1'b0;
            end else if (sweep_shift_q != '0) begin
              shadow_d   = sweep_a[10:0];
              cur_freq_d = sweep_a[10:0];
              period_d   = sqtch_pkg::timer_reload(sweep_a[10:0]);
            end
            if (sweep_b[11]) begin
              chan_en_d = 1'b0;
            end
          end
        end
      end
      sqtch_pkg::OpEnvelope: begin
        if (chan_en_q && (env_period_q != '0)) begin
          env_cnt_d = env_dec;
          if (env_dec == '0) begin
            env_cnt_d = env_period_q;
            if (!env_inc_q && (vol_q != '0)) begin
              vol_d = vol_q - 4'd1;
            end
            if (env_inc_q && (vol_q != sqtch_pkg::VolumeMax)) begin
              vol_d = vol_q + 4'd1;
            end
          end
        end
      end
      sqtch_pkg::OpTrigger: begin
        cur_freq_d  = freq_in;
        chan_en_d   = (env_start_q != '0) || env_inc_q;
        period_d    = sqtch_pkg::timer_reload(freq_in);
        env_cnt_d   = env_period_q;
        vol_d       = env_start_q;
        if (len_cnt_q == '0) begin
          len_cnt_d = (odd_in && len_en_q) ? (sqtch_pkg::LengthFull - 7'd1)
                                           : sqtch_pkg::LengthFull;
        end
        shadow_d    = freq_in;
        sweep_cnt_d = sweep_period_q;
        sweep_act_d = (sweep_period_q != '0) || (sweep_shift_q != '0);
        if ((sweep_shift_q != '0) && trig_calc[11]) begin
          chan_en_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign sample_d = (chan_en_d && level_d) ? vol_d : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_mode_q    <= '0;
      sweep_period_q <= '0;
      sweep_sub_q    <= 1'b0;
      sweep_shift_q  <= '0;
      env_start_q    <= '0;
      env_inc_q      <= 1'b0;
      env_period_q   <= '0;
      len_en_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sqtch_pkg::CfgDutyMode:      duty_mode_q    <= cfg_data_i[1:0];
        sqtch_pkg::CfgSweepPeriod:   sweep_period_q <= cfg_data_i[2:0];
        sqtch_pkg::CfgSweepSubtract: sweep_sub_q    <= cfg_data_i[0];
        sqtch_pkg::CfgSweepShift:    sweep_shift_q  <= cfg_data_i[2:0];
        sqtch_pkg::CfgEnvStartVol:   env_start_q    <= cfg_data_i;
        sqtch_pkg::CfgEnvIncrease:   env_inc_q      <= cfg_data_i[0];
        sqtch_pkg::CfgEnvPeriod:     env_period_q   <= cfg_data_i[2:0];
        sqtch_pkg::CfgLengthEnable:  len_en_q       <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_en_q   <= 1'b0;
      cur_freq_q  <= '0;
      shadow_q    <= '0;
      period_q    <= '0;
      phase_q     <= '0;
      level_q     <= 1'b0;
      vol_q       <= '0;
      env_cnt_q   <= '0;
      sweep_cnt_q <= '0;
      sweep_act_q <= 1'b0;
      len_cnt_q   <= sqtch_pkg::LengthFull;
    end else if (s_acc) begin
      chan_en_q   <= chan_en_d;
      cur_freq_q  <= cur_freq_d;
      shadow_q    <= shadow_d;
      period_q    <= period_d;
      phase_q     <= phase_d;
      level_q     <= level_d;
      vol_q       <= vol_d;
      env_cnt_q   <= env_cnt_d;
      sweep_cnt_q <= sweep_cnt_d;
      sweep_act_q <= sweep_act_d;
      len_cnt_q   <= len_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      out_data_q <= {3'b000, chan_en_d, sample_d};
    end
  end

`ifndef SYNTHESIS
  // dac off at trigger keeps the channel silent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (op == sqtch_pkg::OpTrigger) && (env_start_q == '0) && !env_inc_q
    |=> !chan_en_q)
  else $error("trigger with dac off enabled the channel");

  // the on flag of a new beat follows the channel state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (m_axis_tdata[4] == chan_en_q))
  else $error("output on flag disagrees with channel state");

  // a nonzero sample only while the channel is on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[3:0] != 4'd0) |-> m_axis_tdata[4])
  else $error("sample output while channel off");

  // state only moves on an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_acc |=> $stable(period_q) && $stable(len_cnt_q) && $stable(vol_q))
  else $error("channel state changed without a beat");

  // length counter never above full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_cnt_q <= sqtch_pkg::LengthFull)
  else $error("length counter out of range");
`endif

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the square tone channel with sweep, predicting every output beat
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned FreqTop    = (1 << sqtch_pkg::FreqW) - 1;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 120;

  typedef struct packed {
    logic [sqtch_pkg::OpW-1:0]   op;
    logic [sqtch_pkg::FreqW-1:0] freq;
    logic                        odd;
  } tone_event_t;

  typedef struct packed {
    logic [sqtch_pkg::VolW-1:0] level;
    logic                       on;
  } tone_sample_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [sqtch_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [sqtch_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [15:0]                    s_axis_tdata = '0;   // [10:0] frequency_value, [11] sequencer_odd
  logic [2:0]                     s_axis_tuser = '0;   // [2:0] operation
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [7:0]                     m_axis_tdata;        // [3:0] sample, [4] channel_on

  square_tone_channel_with_sweep_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the registers
  logic [1:0]                 cfg_duty = '0;
  logic [2:0]                 cfg_sweep_period = '0;
  logic                       cfg_sweep_sub = 1'b0;
  logic [2:0]                 cfg_sweep_shift = '0;
  logic [sqtch_pkg::VolW-1:0] cfg_env_start = '0;
  logic                       cfg_env_up = 1'b0;
  logic [2:0]                 cfg_env_period = '0;
  logic                       cfg_length_on = 1'b0;

  // predictor copy of the channel state
  logic                          tone_on = 1'b0;
  logic [sqtch_pkg::FreqW-1:0]   freq_now = '0;
  logic [sqtch_pkg::FreqW-1:0]   freq_shadow = '0;
  logic [sqtch_pkg::PeriodW-1:0] timer_cnt = '0;
  logic [2:0]                    wave_pos = '0;
  logic                          wave_hi = 1'b0;
  logic [sqtch_pkg::VolW-1:0]    volume = '0;
  logic [sqtch_pkg::CntW-1:0]    env_div = '0;
  logic [sqtch_pkg::CntW-1:0]    sweep_div = '0;
  logic                          sweep_armed = 1'b0;
  logic [sqtch_pkg::LengthW-1:0] length_left = sqtch_pkg::LengthFull;

  tone_event_t  pending_events[$];
  tone_sample_t expected_samples[$];

  int unsigned mismatches = 0;
  int unsigned out_beats = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;

  function automatic logic [sqtch_pkg::PeriodW-1:0] period_reload(
      input logic [sqtch_pkg::FreqW-1:0] f);
    return sqtch_pkg::PeriodW'(2 * (FreqTop + 1 - int'(f)));
  endfunction

  function automatic void sweep_apply(input logic write_back);
    int unsigned delta;
    int unsigned target;
    if (!sweep_armed) return;
    delta = int'(freq_shadow) >> cfg_sweep_shift;
    if (cfg_sweep_sub) begin
      target = int'(freq_shadow) - delta;
    end else begin
      target = int'(freq_shadow) + delta;
    end
    if (target > FreqTop) begin
      tone_on = 1'b0;
    end else if (cfg_sweep_shift != 0 && write_back) begin
      freq_shadow = sqtch_pkg::FreqW'(target);
      freq_now = sqtch_pkg::FreqW'(target);
      timer_cnt = period_reload(freq_now);
    end
  endfunction

  function automatic tone_sample_t tone_channel_step(input tone_event_t ev);
    tone_sample_t res;
    case (ev.op)
      sqtch_pkg::OpTick: begin
        if (timer_cnt != 0) begin
          timer_cnt = timer_cnt - 1'b1;
          if (timer_cnt == 0) begin
            timer_cnt = period_reload(freq_now);
            wave_pos = wave_pos + 1'b1;
            case (cfg_duty)
              2'd0:    wave_hi = (wave_pos == 3'd6);
              2'd1:    wave_hi = (wave_pos >= 3'd6);
              2'd2:    wave_hi = (wave_pos >= 3'd4);
              default: wave_hi = (wave_pos <= 3'd5);
            endcase
          end
        end
      end
      sqtch_pkg::OpLength: begin
        if (cfg_length_on && length_left != 0) begin
          length_left = length_left - 1'b1;
          if (length_left == 0) tone_on = 1'b0;
        end
      end
      sqtch_pkg::OpSweep: begin
        sweep_div = sweep_div - 1'b1;
        if (sweep_div == 0) begin
          sweep_div = cfg_sweep_period;
          if (sweep_armed && cfg_sweep_period != 0) begin
            sweep_apply(1'b1);
            sweep_apply(1'b0);
          end
        end
      end
      sqtch_pkg::OpEnvelope: begin
        if (tone_on && cfg_env_period != 0) begin
          env_div = env_div - 1'b1;
          if (env_div == 0) begin
            env_div = cfg_env_period;
            if (!cfg_env_up && volume > 0) volume = volume - 1'b1;
            if (cfg_env_up && volume < sqtch_pkg::VolumeMax) volume = volume + 1'b1;
          end
        end
      end
      sqtch_pkg::OpTrigger: begin
        freq_now = ev.freq;
        tone_on = (cfg_env_start != 0) || cfg_env_up;
        timer_cnt = period_reload(freq_now);
        env_div = cfg_env_period;
        volume = cfg_env_start;
        if (length_left == 0) begin
          length_left = sqtch_pkg::LengthFull;
          if (ev.odd && cfg_length_on) length_left = length_left - 1'b1;
        end
        freq_shadow = freq_now;
        sweep_div = cfg_sweep_period;
        sweep_armed = (cfg_sweep_period != 0) || (cfg_sweep_shift != 0);
        if (cfg_sweep_shift != 0) sweep_apply(1'b0);
      end
      default: ;
    endcase
    res.level = (tone_on && wave_hi) ? volume : '0;
    res.on = tone_on;
    return res;
  endfunction

  // driver
  tone_event_t drv_event;
  int unsigned src_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_samples.push_back(tone_channel_step(drv_event));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap == 0 && !calm && $urandom_range(99) < gap_pct) begin
          src_gap = $urandom_range(1, 8);
        end
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          drv_event = pending_events.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'b0, drv_event.odd, drv_event.freq};
          s_axis_tuser <= drv_event.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at output beat %0d: %s expected %0d got %0d",
               out_beats, what, want, got);
    end
  endtask

  // monitor
  tone_sample_t mon_want;
  int unsigned  sink_gap = 0;
  int unsigned  hold_left = 0;
  logic         hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          flag_mismatch("unexpected beat, pending count", 0, 1);
        end else begin
          mon_want = expected_samples.pop_front();
          if (m_axis_tdata[sqtch_pkg::VolW-1:0] !== mon_want.level) begin
            flag_mismatch("sample", mon_want.level, m_axis_tdata[sqtch_pkg::VolW-1:0]);
          end
          if (m_axis_tdata[sqtch_pkg::VolW] !== mon_want.on) begin
            flag_mismatch("channel_on", mon_want.on, m_axis_tdata[sqtch_pkg::VolW]);
          end
        end
        out_beats++;
      end
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (sink_gap == 0 && !calm && $urandom_range(99) < stall_pct) begin
          sink_gap = $urandom_range(1, 8);
        end
        if (sink_gap > 0) begin
          sink_gap--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic void queue_event(input logic [sqtch_pkg::OpW-1:0] op,
                                      input logic [sqtch_pkg::FreqW-1:0] freq,
                                      input logic odd);
    tone_event_t ev;
    ev.op = op;
    ev.freq = freq;
    ev.odd = odd;
    pending_events.push_back(ev);
  endfunction

  task automatic write_reg(input logic [sqtch_pkg::CfgIdxW-1:0] idx,
                           input logic [sqtch_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      sqtch_pkg::CfgDutyMode:      cfg_duty = val[1:0];
      sqtch_pkg::CfgSweepPeriod:   cfg_sweep_period = val[2:0];
      sqtch_pkg::CfgSweepSubtract: cfg_sweep_sub = val[0];
      sqtch_pkg::CfgSweepShift:    cfg_sweep_shift = val[2:0];
      sqtch_pkg::CfgEnvStartVol:   cfg_env_start = val;
      sqtch_pkg::CfgEnvIncrease:   cfg_env_up = val[0];
      sqtch_pkg::CfgEnvPeriod:     cfg_env_period = val[2:0];
      sqtch_pkg::CfgLengthEnable:  cfg_length_on = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int unsigned duty, input int unsigned sw_period,
                               input int unsigned sw_sub, input int unsigned sw_shift,
                               input int unsigned env_start, input int unsigned env_up,
                               input int unsigned env_period, input int unsigned len_on);
    write_reg(sqtch_pkg::CfgDutyMode, sqtch_pkg::CfgDataW'(duty));
    write_reg(sqtch_pkg::CfgSweepPeriod, sqtch_pkg::CfgDataW'(sw_period));
    write_reg(sqtch_pkg::CfgSweepSubtract, sqtch_pkg::CfgDataW'(sw_sub));
    write_reg(sqtch_pkg::CfgSweepShift, sqtch_pkg::CfgDataW'(sw_shift));
    write_reg(sqtch_pkg::CfgEnvStartVol, sqtch_pkg::CfgDataW'(env_start));
    write_reg(sqtch_pkg::CfgEnvIncrease, sqtch_pkg::CfgDataW'(env_up));
    write_reg(sqtch_pkg::CfgEnvPeriod, sqtch_pkg::CfgDataW'(env_period));
    write_reg(sqtch_pkg::CfgLengthEnable, sqtch_pkg::CfgDataW'(len_on));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || s_axis_tvalid || expected_samples.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned r;
    logic [sqtch_pkg::OpW-1:0] op;
    logic [sqtch_pkg::FreqW-1:0] freq;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 45) op = sqtch_pkg::OpTick;
      else if (r < 60) op = sqtch_pkg::OpLength;
      else if (r < 72) op = sqtch_pkg::OpSweep;
      else if (r < 84) op = sqtch_pkg::OpEnvelope;
      else if (r < 94) op = sqtch_pkg::OpTrigger;
      else op = sqtch_pkg::OpW'($urandom_range(sqtch_pkg::OpTrigger + 1,
                                               (1 << sqtch_pkg::OpW) - 1));
      if ($urandom_range(99) < 60) begin
        freq = sqtch_pkg::FreqW'($urandom_range(FreqTop - 63, FreqTop));
      end else begin
        freq = sqtch_pkg::FreqW'($urandom_range(FreqTop));
      end
      queue_event(op, freq, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    gap_pct <= 20;
    stall_pct <= 20;

    // reset settings: stopped timer, spare codes, idle counters, dac off
    queue_event(sqtch_pkg::OpTick, sqtch_pkg::FreqW'(FreqTop), 1'b1);
    for (int c = sqtch_pkg::OpTrigger + 1; c < (1 << sqtch_pkg::OpW); c++) begin
      queue_event(sqtch_pkg::OpW'(c), '0, 1'b0);
    end
    queue_event(sqtch_pkg::OpEnvelope, '0, 1'b0);
    queue_event(sqtch_pkg::OpSweep, '0, 1'b0);
    queue_event(sqtch_pkg::OpLength, '0, 1'b1);
    queue_event(sqtch_pkg::OpTrigger, 11'd1234, 1'b0);
    wait_drained();

    // subtracting sweep with write back, fast timer, envelope and length steps
    apply_setting(3, 1, 1, 1, 15, 0, 1, 1);
    queue_event(sqtch_pkg::OpTrigger, sqtch_pkg::FreqW'(FreqTop), 1'b1);
    queue_event(sqtch_pkg::OpTick, '0, 1'b0);
    queue_event(sqtch_pkg::OpTick, '0, 1'b0);
    queue_event(sqtch_pkg::OpEnvelope, '0, 1'b0);
    queue_event(sqtch_pkg::OpSweep, '0, 1'b0);
    queue_event(sqtch_pkg::OpLength, '0, 1'b0);
    queue_event(sqtch_pkg::OpTick, 11'h555, 1'b1);
    wait_drained();

    // sweep overflow with period zero, rising envelope from silence
    apply_setting(0, 0, 0, 7, 0, 1, 7, 0);
    queue_event(sqtch_pkg::OpTrigger, '0, 1'b0);
    queue_event(sqtch_pkg::OpSweep, '0, 1'b0);
    queue_event(sqtch_pkg::OpTrigger, sqtch_pkg::FreqW'(FreqTop), 1'b0);
    queue_event(sqtch_pkg::OpTick, 11'h2aa, 1'b0);
    wait_drained();

    for (int k = 0; k < 6; k++) begin
      gap_pct <= (k == 3) ? 0 : 15 + 10 * (k % 2);
      stall_pct <= (k == 3) ? 0 : 25 - 10 * (k % 2);
      if (k == 5) calm <= 1'b1;
      if (k == 0) begin
        apply_setting(3, 7, 1, 7, 15, 1, 7, 1);
      end else if (k == 1) begin
        apply_setting(0, 0, 0, 0, 15, 0, 0, 0);
      end else begin
        apply_setting($urandom_range(3), $urandom_range(7), $urandom_range(1),
                      $urandom_range(7), $urandom_range(15), $urandom_range(1),
                      $urandom_range(7), 1);
      end
      queue_random(250);
      if (k == 2) hold_req <= 1'b1;
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/sqtch_pkg.sv
design/square_tone_channel_with_sweep_unit.sv
tb/testbench.sv
